// File: rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, codes and helpers for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic OPN_PUSH  = 1'b0;
    localparam logic OPN_APPLY = 1'b1;

    localparam logic [7:0] OP_ADD = 8'h2B;
    localparam logic [7:0] OP_SUB = 8'h2D;
    localparam logic [7:0] OP_MUL = 8'h2A;
    localparam logic [7:0] OP_DIV = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_BADOP     = 3'd4
    } status_t;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] number_value;
        logic [7:0]         operator_char;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic               top_valid;
        logic [6:0]         stack_depth;
        logic [2:0]         status;
    } out_item_t;

    typedef struct packed {
        logic load_token;
        logic push_num;
        logic pop;
        logic take_b;
        logic take_a;
        logic exec;
        logic div_step;
        logic write_res;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic apply_in;
        logic div_go;
        logic div_last;
    } ctrl_sts_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    // apply sign to a magnitude, saturate to 32-bit signed
    function automatic logic [31:0] sign_sat(input logic [63:0] mag, input logic neg);
        logic [31:0] r;
        if (neg) begin
            if (mag >= 64'h0000_0000_8000_0000) r = 32'h8000_0000;
            else r = ~mag[31:0] + 32'd1;
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
            else r = mag[31:0];
        end
        return r;
    endfunction

    // 33-bit signed sum saturated to 32 bits
    function automatic logic [31:0] sum_sat(input logic [32:0] s);
        logic [31:0] r;
        if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else r = s[31:0];
        return r;
    endfunction

endpackage

// File: rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer for the evaluator: steps the datapath through pushes, pops,
// arithmetic, divide iterations, result write, top-of-stack read, result hand-off.
// ----------------------------------------------------------------------------
module pse_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pse_pkg::ctrl_sts_t sts,
    output pse_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_PUSH    = 10'b00_0000_0010,
        S_POP_B   = 10'b00_0000_0100,
        S_POP_A   = 10'b00_0000_1000,
        S_TAKE_A  = 10'b00_0001_0000,
        S_EXEC    = 10'b00_0010_0000,
        S_DIV_RUN = 10'b00_0100_0000,
        S_WRITE   = 10'b00_1000_0000,
        S_RD_TOP  = 10'b01_0000_0000,
        S_OUT     = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_token = 1'b1;
                    state_next = (sts.apply_in == pse_pkg::OPN_APPLY) ? S_POP_B : S_PUSH;
                end
            end
            S_PUSH: begin
                cmd.push_num = 1'b1;
                state_next = S_RD_TOP;
            end
            S_POP_B: begin
                cmd.pop = 1'b1;
                state_next = S_POP_A;
            end
            S_POP_A: begin
                cmd.take_b = 1'b1;
                cmd.pop    = 1'b1;
                state_next = S_TAKE_A;
            end
            S_TAKE_A: begin
                cmd.take_a = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                state_next = sts.div_go ? S_DIV_RUN : S_WRITE;
            end
            S_DIV_RUN: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = S_WRITE;
            end
            S_WRITE: begin
                cmd.write_res = 1'b1;
                state_next = S_RD_TOP;
            end
            S_RD_TOP: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/pse_dpath.sv
// ----------------------------------------------------------------------------
// pse_dpath
// Operand stack memory, stack count, operand registers, add/sub, multiplier,
// radix-2 restoring divider and the result register.
// ----------------------------------------------------------------------------
module pse_dpath #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = pse_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pse_pkg::in_item_t   s_payload,
    output pse_pkg::out_item_t  m_payload,
    input  pse_pkg::ctrl_cmd_t  cmd,
    output pse_pkg::ctrl_sts_t  sts
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [31:0] NEG_ONE = ~((32'd1 << FRAC_BITS) - 32'd1);

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rdata_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cnt_m1;
    logic          empty;
    logic          full;

    pse_pkg::in_item_t tok_reg;
    logic [31:0] a_reg, b_reg;
    logic        pend_under_reg;
    logic        under_reg;
    logic        push_reg;
    logic        neg_reg;
    logic [2:0]  status_reg;
    logic [31:0] arith_reg;
    logic [63:0] prod_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic        ovf_reg;
    logic [4:0]  iter_reg;

    logic [31:0] mag_a, mag_b;
    logic [63:0] div_num;
    logic [32:0] div_t;
    logic        div_ge;
    logic [32:0] div_diff;
    logic        is_add, is_sub, is_mul, is_div, b_zero;
    logic [31:0] res_val;
    logic        mem_we;
    logic [31:0] mem_wdata;

    pse_pkg::out_item_t out_reg;

    assign cnt_m1 = count_reg - CW'(1);
    assign empty  = (count_reg == '0);
    assign full   = (count_reg >= CW'(STACK_DEPTH));

    assign mag_a   = pse_pkg::mag32(a_reg);
    assign mag_b   = pse_pkg::mag32(b_reg);
    assign div_num = {32'd0, mag_a} << FRAC_BITS;
    assign b_zero  = (b_reg == 32'd0);

    assign is_add = (tok_reg.operator_char == pse_pkg::OP_ADD);
    assign is_sub = (tok_reg.operator_char == pse_pkg::OP_SUB);
    assign is_mul = (tok_reg.operator_char == pse_pkg::OP_MUL);
    assign is_div = (tok_reg.operator_char == pse_pkg::OP_DIV);

    assign div_t    = {rem_reg, quo_reg[31]};
    assign div_ge   = (div_t >= {1'b0, mag_b});
    assign div_diff = div_t - {1'b0, mag_b};

    assign sts.apply_in = s_payload.operation;
    assign sts.div_go   = is_div && !b_zero;
    assign sts.div_last = (iter_reg == 5'd31);

    always_comb begin
        if (is_mul) res_val = pse_pkg::sign_sat(prod_reg >> FRAC_BITS, neg_reg);
        else if (is_div) res_val = pse_pkg::sign_sat(ovf_reg ? 64'hFFFF_FFFF_FFFF_FFFF
                                                             : {32'd0, quo_reg}, neg_reg);
        else res_val = arith_reg;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = res_val;
        if (cmd.push_num) begin
            mem_we    = !full;
            mem_wdata = tok_reg.number_value;
        end else if (cmd.write_res) begin
            mem_we = push_reg;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (mem_we) count_next = count_reg + CW'(1);
        else if (cmd.pop && !empty) count_next = cnt_m1;
    end

    // stack memory
    always_ff @(posedge aclk) begin
        if (mem_we) mem[count_reg[AW-1:0]] <= mem_wdata;
        rdata_reg <= mem[cnt_m1[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) count_reg <= '0;
        else count_reg <= count_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_token) begin
            tok_reg   <= s_payload;
            under_reg <= 1'b0;
        end
        if (cmd.pop) pend_under_reg <= empty;
        if (cmd.take_b) begin
            b_reg <= pend_under_reg ? NEG_ONE : rdata_reg;
            if (pend_under_reg) under_reg <= 1'b1;
        end
        if (cmd.take_a) begin
            a_reg <= pend_under_reg ? NEG_ONE : rdata_reg;
            if (pend_under_reg) under_reg <= 1'b1;
        end
        if (cmd.push_num) begin
            status_reg <= full ? pse_pkg::ST_OVERFLOW : pse_pkg::ST_OK;
        end
        if (cmd.exec) begin
            neg_reg  <= a_reg[31] ^ b_reg[31];
            prod_reg <= mag_a * mag_b;
            rem_reg  <= div_num[63:32];
            quo_reg  <= div_num[31:0];
            ovf_reg  <= (div_num[63:32] >= mag_b);
            iter_reg <= 5'd0;
            if (is_add) arith_reg <= pse_pkg::sum_sat({a_reg[31], a_reg} + {b_reg[31], b_reg});
            else arith_reg <= pse_pkg::sum_sat({a_reg[31], a_reg} - {b_reg[31], b_reg});
            if (!(is_add || is_sub || is_mul || is_div)) begin
                push_reg   <= 1'b0;
                status_reg <= pse_pkg::ST_BADOP;
            end else if (is_div && b_zero) begin
                push_reg   <= 1'b0;
                status_reg <= pse_pkg::ST_DIVZERO;
            end else begin
                push_reg   <= 1'b1;
                status_reg <= under_reg ? pse_pkg::ST_UNDERFLOW : pse_pkg::ST_OK;
            end
        end
        if (cmd.div_step) begin
            rem_reg  <= div_ge ? div_diff[31:0] : div_t[31:0];
            quo_reg  <= {quo_reg[30:0], div_ge};
            iter_reg <= iter_reg + 5'd1;
        end
        if (cmd.load_out) begin
            out_reg.top_value   <= empty ? 32'sd0 : rdata_reg;
            out_reg.top_valid   <= !empty;
            out_reg.stack_depth <= 7'(count_reg);
            out_reg.status      <= status_reg;
        end
    end

    assign m_payload = out_reg;

endmodule

// File: rtl/postfix_stack_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Postfix (RPN) evaluator on signed fixed-point values with a bounded stack.
// ----------------------------------------------------------------------------
// One request is one token: a number to push or an operator (+ - * /) that
// pops two entries and pushes the saturated result, unless it divides by
// zero; every request returns the new top, depth and a status. Tokens are
// handled one at a time; a / with a nonzero divisor iterates in the
// one-bit-per-cycle restoring divider. The operand stack is a
// single-port-write memory with a registered read, so each pop and the final
// top-of-stack read get a state of their own. A finished result waits in an
// output register and a new token is taken once the previous one has been
// moved there.
module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = pse_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pse_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output pse_pkg::out_item_t m_payload
);

    pse_pkg::ctrl_cmd_t cmd;
    pse_pkg::ctrl_sts_t sts;

    pse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pse_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the postfix stack evaluator unit.
// ----------------------------------------------------------------------------
// Tokens go in over a valid/ready request channel, one result per token comes
// back. A short table opens the run with stack underflow, the saturation
// extremes, divide by zero and bad operators. Random postfix streams follow in
// four phases of sender and receiver idling. One stretch per phase floods the
// stack to hit overflow. Results are checked against typed-in table values
// or else against a local fixed-point stack predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC            = pse_pkg::FRAC_BITS_DEF;
    localparam int DEPTH           = pse_pkg::STACK_DEPTH_DEF;
    localparam int ITEMS_PER_PHASE = 310;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SEND_IDLE [4]   = '{0, 78, 0, 9};
    localparam int RECV_STALL [4]  = '{0, 0, 78, 9};

    typedef struct packed {
        pse_pkg::in_item_t  req;
        logic               fixed_exp;
        pse_pkg::out_item_t exp;
    } token_row_t;

    // expectation typed in where it can be read off by hand, predictor elsewhere
    localparam token_row_t DIRECTED [25] = '{
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, 8'h00}, 1'b1,
          '{32'h0000_0000, 1'b0, 7'd0, pse_pkg::ST_BADOP}},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_DIV}, 1'b1,
          '{32'h0001_0000, 1'b1, 7'd1, pse_pkg::ST_UNDERFLOW}},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_SUB}, 1'b1,
          '{32'hFFFE_0000, 1'b1, 7'd1, pse_pkg::ST_UNDERFLOW}},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_MUL}, 1'b1,
          '{32'h0002_0000, 1'b1, 7'd1, pse_pkg::ST_UNDERFLOW}},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_ADD}, 1'b1,
          '{32'h0001_0000, 1'b1, 7'd1, pse_pkg::ST_UNDERFLOW}},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, 8'hFF}, 1'b1,
          '{32'h0000_0000, 1'b0, 7'd0, pse_pkg::ST_BADOP}},
        '{'{pse_pkg::OPN_PUSH, 32'h0000_0000, 8'h00}, 1'b1,
          '{32'h0000_0000, 1'b1, 7'd1, pse_pkg::ST_OK}},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_DIV}, 1'b1,
          '{32'h0000_0000, 1'b0, 7'd0, pse_pkg::ST_DIVZERO}},
        '{'{pse_pkg::OPN_PUSH, 32'h7FFF_FFFF, 8'h00}, 1'b1,
          '{32'h7FFF_FFFF, 1'b1, 7'd1, pse_pkg::ST_OK}},
        '{'{pse_pkg::OPN_PUSH, 32'h7FFF_FFFF, 8'hFF}, 1'b1,
          '{32'h7FFF_FFFF, 1'b1, 7'd2, pse_pkg::ST_OK}},
        '{'{pse_pkg::OPN_APPLY, 32'hFFFF_FFFF, pse_pkg::OP_ADD}, 1'b1,
          '{32'h7FFF_FFFF, 1'b1, 7'd1, pse_pkg::ST_OK}},
        '{'{pse_pkg::OPN_PUSH, 32'h8000_0000, 8'h00}, 1'b1,
          '{32'h8000_0000, 1'b1, 7'd2, pse_pkg::ST_OK}},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_SUB}, 1'b1,
          '{32'h7FFF_FFFF, 1'b1, 7'd1, pse_pkg::ST_OK}},
        '{'{pse_pkg::OPN_PUSH, 32'h8000_0000, 8'h00}, 1'b0, '0},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_ADD}, 1'b0, '0},
        '{'{pse_pkg::OPN_PUSH, 32'h8000_0000, 8'h00}, 1'b0, '0},
        '{'{pse_pkg::OPN_PUSH, 32'h8000_0000, 8'h00}, 1'b0, '0},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_MUL}, 1'b0, '0},
        '{'{pse_pkg::OPN_PUSH, 32'hFFFF_FFFF, 8'h00}, 1'b0, '0},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_DIV}, 1'b0, '0},
        '{'{pse_pkg::OPN_PUSH, 32'h0001_8000, 8'h00}, 1'b0, '0},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_MUL}, 1'b0, '0},
        '{'{pse_pkg::OPN_PUSH, 32'h0003_0000, 8'h00}, 1'b0, '0},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, pse_pkg::OP_DIV}, 1'b0, '0},
        '{'{pse_pkg::OPN_APPLY, 32'h0000_0000, 8'h2C}, 1'b1,
          '{32'h0000_0000, 1'b0, 7'd0, pse_pkg::ST_BADOP}}
    };

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    pse_pkg::in_item_t  s_payload = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    pse_pkg::out_item_t m_payload;

    logic signed [31:0] shadow_stack [DEPTH];
    int                 shadow_depth = 0;
    pse_pkg::out_item_t expected_tops [$];
    pse_pkg::out_item_t oldest_top;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 mismatch_cnt   = 0;
    int                 stall_cycles   = 0;

    postfix_stack_evaluator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic signed [63:0] pop_operand();
        if (shadow_depth == 0) return -(64'sd1 <<< FRAC);
        shadow_depth--;
        return 64'(shadow_stack[shadow_depth]);
    endfunction

    function automatic logic [63:0] magnitude64(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [31:0] sat_signed(input logic [63:0] m, input bit neg);
        if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : -m[31:0];
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // steps the local stack by one token and returns the result it should give
    function automatic pse_pkg::out_item_t eval_token(input pse_pkg::in_item_t t);
        pse_pkg::out_item_t r;
        pse_pkg::status_t   st;
        logic signed [63:0] a, b;
        logic [31:0]        res;
        bit                 under, keep, neg;
        st   = pse_pkg::ST_OK;
        res  = '0;
        keep = 1'b1;
        if (t.operation == pse_pkg::OPN_PUSH) begin
            if (shadow_depth >= DEPTH) begin
                st = pse_pkg::ST_OVERFLOW;
            end else begin
                shadow_stack[shadow_depth] = t.number_value;
                shadow_depth++;
            end
        end else begin
            under = (shadow_depth < 2);
            b     = pop_operand();
            a     = pop_operand();
            neg   = (a < 0) != (b < 0);
            case (t.operator_char)
                pse_pkg::OP_ADD: res = clamp32(a + b);
                pse_pkg::OP_SUB: res = clamp32(a - b);
                pse_pkg::OP_MUL: begin
                    res = sat_signed((magnitude64(a) * magnitude64(b)) >> FRAC, neg);
                end
                pse_pkg::OP_DIV: begin
                    if (b == 0) begin
                        keep = 1'b0;
                        st   = pse_pkg::ST_DIVZERO;
                    end else begin
                        res = sat_signed((magnitude64(a) << FRAC) / magnitude64(b), neg);
                    end
                end
                default: begin
                    keep = 1'b0;
                    st   = pse_pkg::ST_BADOP;
                end
            endcase
            if (st == pse_pkg::ST_OK && under) st = pse_pkg::ST_UNDERFLOW;
            if (keep && shadow_depth < DEPTH) begin
                shadow_stack[shadow_depth] = res;
                shadow_depth++;
            end
        end
        r.top_valid   = (shadow_depth > 0);
        r.top_value   = r.top_valid ? shadow_stack[shadow_depth - 1] : '0;
        r.stack_depth = 7'(shadow_depth);
        r.status      = st;
        return r;
    endfunction

    function automatic logic [31:0] pick_number();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = 32'h0000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            3, 4: v = $urandom;
            5: v = $urandom_range(100) << FRAC;
            6: v = 32'h0000_0001;
            default: v = $urandom_range(32'h007F_FFFF);
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    // mostly well-formed postfix streams, a little noise; flood piles up pushes
    function automatic pse_pkg::in_item_t make_token(input bit flood);
        pse_pkg::in_item_t t;
        int                roll;
        t.number_value  = pick_number();
        t.operator_char = 8'($urandom);
        roll            = $urandom_range(99);
        if (flood) begin
            t.operation = (roll < 95) ? pse_pkg::OPN_PUSH : pse_pkg::OPN_APPLY;
        end else if (roll < 3) begin
            t.operation = pse_pkg::OPN_APPLY;
        end else if (shadow_depth < 2) begin
            t.operation = pse_pkg::OPN_PUSH;
        end else if (shadow_depth > 12) begin
            t.operation = (roll < 80) ? pse_pkg::OPN_APPLY : pse_pkg::OPN_PUSH;
        end else begin
            t.operation = (roll < 45) ? pse_pkg::OPN_APPLY : pse_pkg::OPN_PUSH;
        end
        if (t.operation == pse_pkg::OPN_APPLY && $urandom_range(99) >= 6) begin
            case ($urandom_range(3))
                0: t.operator_char = pse_pkg::OP_ADD;
                1: t.operator_char = pse_pkg::OP_SUB;
                2: t.operator_char = pse_pkg::OP_MUL;
                default: t.operator_char = pse_pkg::OP_DIV;
            endcase
        end
        return t;
    endfunction

    task automatic send_token(input pse_pkg::in_item_t req, input logic fixed_exp,
                              input pse_pkg::out_item_t exp);
        pse_pkg::out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = eval_token(req);
        expected_tops.push_back(fixed_exp ? exp : predicted);
    endtask

    task automatic log_mismatch(input string what, input pse_pkg::out_item_t want,
                                input pse_pkg::out_item_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("mismatch %0d (%s): exp top=%h valid=%b depth=%0d status=%0d",
                     mismatch_cnt, what, want.top_value, want.top_valid,
                     want.stack_depth, want.status);
            $display("    got top=%h valid=%b depth=%0d status=%0d",
                     got.top_value, got.top_valid, got.stack_depth, got.status);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_tops.size() == 0) begin
                log_mismatch("no request pending", '0, m_payload);
            end else begin
                oldest_top = expected_tops.pop_front();
                if (m_payload.top_value !== oldest_top.top_value ||
                    m_payload.top_valid !== oldest_top.top_valid ||
                    m_payload.stack_depth !== oldest_top.stack_depth ||
                    m_payload.status !== oldest_top.status)
                    log_mismatch("field", oldest_top, m_payload);
            end
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < $size(DIRECTED); i++)
            send_token(DIRECTED[i].req, DIRECTED[i].fixed_exp, DIRECTED[i].exp);
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_token(make_token(i >= 100 && i < 180), 1'b0, '0);
            // hold off until every result of this phase is back
            s_valid <= 1'b0;
            while (expected_tops.size() != 0) @(posedge aclk);
        end
        repeat (64) @(posedge aclk);
        if (mismatch_cnt == 0 && expected_tops.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/pse_pkg.sv
rtl/pse_ctrl.sv
rtl/pse_dpath.sv
rtl/postfix_stack_evaluator_unit.sv
tb/tb.sv
